@@ sv/aqac_pkg.sv @@
// aqac_pkg: shared types, codes and datapath constants for the air quality
// alarm classifier. No dependencies; compile first.
`timescale 1ns / 1ps

package aqac_pkg;

    // Converter full scale and field widths
    localparam int ADC_FULL_SCALE = 4095;
    localparam int GAS_W          = 12;
    localparam int DUST_RAW_W     = 12;
    localparam int DUST_W         = 16;
    localparam int GAIN_W         = 16;
    localparam int INDEX_W        = 10;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int GAIN_FRAC      = 8;

    // Clean-air index arithmetic
    localparam int INDEX_MAX = 1000;
    localparam int CLAMP_W   = 16;
    localparam int SUM_W     = $clog2(2 * ADC_FULL_SCALE + 1);
    localparam int NUM_MAX   = (2 * INDEX_MAX + 1) * ADC_FULL_SCALE;
    localparam int NUM_W     = $clog2(NUM_MAX + 1);
    localparam int DIV       = 2 * ADC_FULL_SCALE;
    localparam int RECIP_K   = NUM_W;
    localparam int RECIP_M   = (1 << RECIP_K) / DIV;
    localparam int RECIP_W   = $clog2(RECIP_M + 1);
    localparam int PROD_W    = NUM_W + RECIP_W;
    localparam int DROP_W    = INDEX_W;

    // Threshold reset values
    localparam int GAS_WARN_RST   = 1500;
    localparam int GAS_HAZ_RST    = 2500;
    localparam int DUST_WARN_RST  = 1500;
    localparam int DUST_HAZ_RST   = 2500;
    localparam int INDEX_HAZ_RST  = 400;
    localparam int DUST_GAIN_RST  = 256;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GAS_WARN   = 3'd0,
        CFG_GAS_HAZ    = 3'd1,
        CFG_DUST_WARN  = 3'd2,
        CFG_DUST_HAZ   = 3'd3,
        CFG_INDEX_HAZ  = 3'd4,
        CFG_DUST_GAIN  = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_SAFE = 2'd0,
        ST_WARN = 2'd1,
        ST_HAZ  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BUZZ_NONE  = 2'd0,
        BUZZ_SHORT = 2'd1,
        BUZZ_LONG  = 2'd2
    } buzz_t;

    typedef enum logic [1:0] {
        SEV_NONE   = 2'd0,
        SEV_HAZARD = 2'd1,
        SEV_CHANGE = 2'd2
    } status_event_t;

    typedef enum logic [1:0] {
        FEV_NONE = 2'd0,
        FEV_ON   = 2'd1,
        FEV_OFF  = 2'd2
    } fan_event_t;

    typedef struct packed {
        status_t              air_status;
        logic [INDEX_W-1:0]   clean_index;
        logic [DUST_W-1:0]    dust_scaled;
        logic                 fan_drive;
        logic                 led_drive;
        buzz_t                buzzer_pulse;
        status_event_t        status_event;
        fan_event_t           fan_event;
    } result_t;

endpackage

@@ sv/aqac_if.sv @@
// aqac channel interfaces: measurement, result and configuration write.
// Depends on aqac_pkg for field widths.
`timescale 1ns / 1ps

interface aqac_meas_if;
    logic                             valid;
    logic                             ready;
    logic [aqac_pkg::GAS_W-1:0]       gas_level;
    logic [aqac_pkg::DUST_RAW_W-1:0]  dust_sample;

    modport source (output valid, output gas_level, output dust_sample, input ready);
    modport sink   (input valid, input gas_level, input dust_sample, output ready);
endinterface

interface aqac_result_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      air_status;
    logic [aqac_pkg::INDEX_W-1:0]    clean_index;
    logic [aqac_pkg::DUST_W-1:0]     dust_scaled;
    logic                            fan_drive;
    logic                            led_drive;
    logic [1:0]                      buzzer_pulse;
    logic [1:0]                      status_event;
    logic [1:0]                      fan_event;

    modport source (output valid, output air_status, output clean_index, output dust_scaled,
                    output fan_drive, output led_drive, output buzzer_pulse,
                    output status_event, output fan_event, input ready);
    modport sink   (input valid, input air_status, input clean_index, input dust_scaled,
                    input fan_drive, input led_drive, input buzzer_pulse,
                    input status_event, input fan_event, output ready);
endinterface

interface aqac_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [aqac_pkg::CFG_INDEX_W-1:0]   index;
    logic [aqac_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/air_quality_alarm_classifier.sv @@
// air_quality_alarm_classifier: top level, four-stage classifier pipeline.
// Depends on aqac_pkg and the channel interfaces in aqac_if.sv.
`timescale 1ns / 1ps

// Channel   Direction  Payload                                     Request moves
// cfg       in         index, data                                 one register write
// meas      in         gas_level, dust_sample                      one measurement
// res       out        air_status .. fan_event (eight fields)      one classified result
//
// One request is taken every cycle unless a full pipeline is held by the
// result receiver. Stages: dust gain multiply, index numerator, reciprocal
// multiply, then correction and classification, which update the alarm
// latch and fan state in order. A stage holds its request while its
// successor is full and stalled, so bubbles collapse. Reset clears valid
// bits and alarm state and restores the thresholds; config writes always go in.

module air_quality_alarm_classifier (
    input  logic                  clk,
    input  logic                  rst_n,
    aqac_cfg_if.sink              cfg,
    aqac_meas_if.sink             meas,
    aqac_result_if.source         res
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [aqac_pkg::GAS_W-1:0]     gas_warn_reg;
    logic [aqac_pkg::GAS_W-1:0]     gas_haz_reg;
    logic [aqac_pkg::DUST_W-1:0]    dust_warn_reg;
    logic [aqac_pkg::DUST_W-1:0]    dust_haz_reg;
    logic [aqac_pkg::INDEX_W-1:0]   index_haz_reg;
    logic [aqac_pkg::GAIN_W-1:0]    dust_gain_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gas_warn_reg  <= aqac_pkg::GAS_W'(aqac_pkg::GAS_WARN_RST);
            gas_haz_reg   <= aqac_pkg::GAS_W'(aqac_pkg::GAS_HAZ_RST);
            dust_warn_reg <= aqac_pkg::DUST_W'(aqac_pkg::DUST_WARN_RST);
            dust_haz_reg  <= aqac_pkg::DUST_W'(aqac_pkg::DUST_HAZ_RST);
            index_haz_reg <= aqac_pkg::INDEX_W'(aqac_pkg::INDEX_HAZ_RST);
            dust_gain_reg <= aqac_pkg::GAIN_W'(aqac_pkg::DUST_GAIN_RST);
        end
        else if (cfg.valid && cfg.ready)
        begin
            // Decode the register index; unknown indexes drop the write
            unique case (aqac_pkg::cfg_reg_t'(cfg.index))
                aqac_pkg::CFG_GAS_WARN:  gas_warn_reg  <= cfg.data[aqac_pkg::GAS_W-1:0];
                aqac_pkg::CFG_GAS_HAZ:   gas_haz_reg   <= cfg.data[aqac_pkg::GAS_W-1:0];
                aqac_pkg::CFG_DUST_WARN: dust_warn_reg <= cfg.data[aqac_pkg::DUST_W-1:0];
                aqac_pkg::CFG_DUST_HAZ:  dust_haz_reg  <= cfg.data[aqac_pkg::DUST_W-1:0];
                aqac_pkg::CFG_INDEX_HAZ: index_haz_reg <= cfg.data[aqac_pkg::INDEX_W-1:0];
                aqac_pkg::CFG_DUST_GAIN: dust_gain_reg <= cfg.data[aqac_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage control: each stage advances when it is empty or its
    // successor advances.
    // ------------------------------------------------------------------
    logic s1_v_reg, s2_v_reg, s3_v_reg, out_v_reg;
    logic adv0, adv1, adv2, adv3;

    assign adv3 = !out_v_reg || res.ready;
    assign adv2 = !s3_v_reg  || adv3;
    assign adv1 = !s2_v_reg  || adv2;
    assign adv0 = !s1_v_reg  || adv1;

    assign meas.ready = adv0;
    assign res.valid  = out_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (adv0)
                s1_v_reg <= meas.valid;
            if (adv1)
                s2_v_reg <= s1_v_reg;
            if (adv2)
                s3_v_reg <= s2_v_reg;
            if (adv3)
                out_v_reg <= s3_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: apply the Q8.8 dust gain, truncate and saturate to 16 bits
    // ------------------------------------------------------------------
    localparam int MUL_W = aqac_pkg::DUST_RAW_W + aqac_pkg::GAIN_W;

    logic [MUL_W-1:0]                dust_prod;
    logic [MUL_W-aqac_pkg::GAIN_FRAC-1:0] dust_shift;
    logic [aqac_pkg::DUST_W-1:0]     dust_sat;

    assign dust_prod  = MUL_W'(meas.dust_sample) * MUL_W'(dust_gain_reg);
    assign dust_shift = dust_prod[MUL_W-1:aqac_pkg::GAIN_FRAC];
    assign dust_sat   = (|dust_shift[MUL_W-aqac_pkg::GAIN_FRAC-1:aqac_pkg::DUST_W])
                        ? {aqac_pkg::DUST_W{1'b1}}
                        : dust_shift[aqac_pkg::DUST_W-1:0];

    logic [aqac_pkg::GAS_W-1:0]  s1_gas_reg;
    logic [aqac_pkg::DUST_W-1:0] s1_dust_reg;

    always_ff @(posedge clk)
    begin
        if (adv0)
        begin
            s1_gas_reg  <= meas.gas_level;
            s1_dust_reg <= dust_sat;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: clamp to full scale, form 1000 * sum + full_scale
    // ------------------------------------------------------------------
    localparam logic [aqac_pkg::CLAMP_W-1:0] FS_C = aqac_pkg::CLAMP_W'(aqac_pkg::ADC_FULL_SCALE);

    logic [aqac_pkg::CLAMP_W-1:0] gas_wide, dust_wide, gas_clamp, dust_clamp;
    logic [aqac_pkg::SUM_W-1:0]   reading_sum;
    logic [aqac_pkg::NUM_W-1:0]   index_num;

    assign gas_wide    = aqac_pkg::CLAMP_W'(s1_gas_reg);
    assign dust_wide   = aqac_pkg::CLAMP_W'(s1_dust_reg);
    assign gas_clamp   = (gas_wide > FS_C) ? FS_C : gas_wide;
    assign dust_clamp  = (dust_wide > FS_C) ? FS_C : dust_wide;
    assign reading_sum = aqac_pkg::SUM_W'(gas_clamp) + aqac_pkg::SUM_W'(dust_clamp);
    assign index_num   = aqac_pkg::NUM_W'(reading_sum) * aqac_pkg::NUM_W'(aqac_pkg::INDEX_MAX)
                         + aqac_pkg::NUM_W'(aqac_pkg::ADC_FULL_SCALE);

    logic [aqac_pkg::GAS_W-1:0]  s2_gas_reg;
    logic [aqac_pkg::DUST_W-1:0] s2_dust_reg;
    logic [aqac_pkg::NUM_W-1:0]  s2_num_reg;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s2_gas_reg  <= s1_gas_reg;
            s2_dust_reg <= s1_dust_reg;
            s2_num_reg  <= index_num;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: estimate num / (2 * full_scale) by reciprocal multiply.
    // The estimate is never high and at most one below the true quotient.
    // ------------------------------------------------------------------
    logic [aqac_pkg::PROD_W-1:0] recip_prod;

    assign recip_prod = aqac_pkg::PROD_W'(s2_num_reg) * aqac_pkg::PROD_W'(aqac_pkg::RECIP_M);

    logic [aqac_pkg::GAS_W-1:0]  s3_gas_reg;
    logic [aqac_pkg::DUST_W-1:0] s3_dust_reg;
    logic [aqac_pkg::NUM_W-1:0]  s3_num_reg;
    logic [aqac_pkg::DROP_W-1:0] s3_q0_reg;

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s3_gas_reg  <= s2_gas_reg;
            s3_dust_reg <= s2_dust_reg;
            s3_num_reg  <= s2_num_reg;
            s3_q0_reg   <= recip_prod[aqac_pkg::RECIP_K +: aqac_pkg::DROP_W];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: correct the quotient, build the index, classify and
    // update the alarm latch, fan state and last status.
    // ------------------------------------------------------------------
    localparam logic [aqac_pkg::NUM_W-1:0]   DIV_N   = aqac_pkg::NUM_W'(aqac_pkg::DIV);
    localparam logic [aqac_pkg::DROP_W-1:0]  IDX_MAX = aqac_pkg::DROP_W'(aqac_pkg::INDEX_MAX);

    aqac_pkg::status_t prev_status_reg, prev_status_next;
    logic              armed_reg, armed_next;
    logic              fan_state_reg, fan_state_next;

    logic [aqac_pkg::NUM_W-1:0]   q0_times_div;
    logic [aqac_pkg::NUM_W-1:0]   remainder;
    logic [aqac_pkg::DROP_W-1:0]  drop_fix;
    logic [aqac_pkg::DROP_W-1:0]  drop_sat;
    logic [aqac_pkg::INDEX_W-1:0] clean_idx;
    aqac_pkg::status_t            status;
    aqac_pkg::result_t            result_next;
    aqac_pkg::result_t            result_reg;

    always_comb
    begin
        q0_times_div = aqac_pkg::NUM_W'(s3_q0_reg) * DIV_N;
        remainder    = s3_num_reg - q0_times_div;
        drop_fix     = (remainder >= DIV_N) ? s3_q0_reg + aqac_pkg::DROP_W'(1) : s3_q0_reg;
        drop_sat     = (drop_fix > IDX_MAX) ? IDX_MAX : drop_fix;
        clean_idx    = IDX_MAX - drop_sat;

        // Thresholds see the unclamped readings
        if (s3_gas_reg > gas_haz_reg || s3_dust_reg > dust_haz_reg || clean_idx < index_haz_reg)
            status = aqac_pkg::ST_HAZ;
        else if (s3_gas_reg > gas_warn_reg || s3_dust_reg > dust_warn_reg)
            status = aqac_pkg::ST_WARN;
        else
            status = aqac_pkg::ST_SAFE;

        result_next              = '0;
        result_next.air_status   = status;
        result_next.clean_index  = clean_idx;
        result_next.dust_scaled  = s3_dust_reg;
        result_next.buzzer_pulse = aqac_pkg::BUZZ_NONE;
        result_next.status_event = aqac_pkg::SEV_NONE;
        result_next.fan_event    = aqac_pkg::FEV_NONE;

        armed_next       = armed_reg;
        prev_status_next = status;

        // Safe re-arms the latch; the first non-safe result fires the buzzer
        if (status == aqac_pkg::ST_SAFE)
        begin
            fan_state_next = 1'b0;
            armed_next     = 1'b1;
        end
        else
        begin
            fan_state_next = 1'b1;
            if (armed_reg)
            begin
                result_next.buzzer_pulse = (status == aqac_pkg::ST_HAZ)
                                           ? aqac_pkg::BUZZ_LONG : aqac_pkg::BUZZ_SHORT;
                armed_next = 1'b0;
            end
        end
        result_next.fan_drive = fan_state_next;
        result_next.led_drive = fan_state_next;

        if (status != prev_status_reg)
            result_next.status_event = (status == aqac_pkg::ST_HAZ)
                                       ? aqac_pkg::SEV_HAZARD : aqac_pkg::SEV_CHANGE;

        if (fan_state_next && !fan_state_reg)
            result_next.fan_event = aqac_pkg::FEV_ON;
        else if (!fan_state_next && fan_state_reg)
            result_next.fan_event = aqac_pkg::FEV_OFF;
    end

    // Alarm state advances only when a request moves into the result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_status_reg <= aqac_pkg::ST_SAFE;
            armed_reg       <= 1'b1;
            fan_state_reg   <= 1'b0;
        end
        else if (adv3 && s3_v_reg)
        begin
            prev_status_reg <= prev_status_next;
            armed_reg       <= armed_next;
            fan_state_reg   <= fan_state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
            result_reg <= result_next;
    end

    assign res.air_status   = result_reg.air_status;
    assign res.clean_index  = result_reg.clean_index;
    assign res.dust_scaled  = result_reg.dust_scaled;
    assign res.fan_drive    = result_reg.fan_drive;
    assign res.led_drive    = result_reg.led_drive;
    assign res.buzzer_pulse = result_reg.buzzer_pulse;
    assign res.status_event = result_reg.status_event;
    assign res.fan_event    = result_reg.fan_event;

endmodule

@@ dv/aqac_verdict_checker.sv @@
// aqac_verdict_checker: watches the configuration, measurement and result channels of
// the air quality alarm classifier, predicts every result and compares it field by field.
// Depends on aqac_pkg and the channel interfaces in aqac_if.sv.
`timescale 1ns / 1ps

module aqac_verdict_checker (
    input  logic    clk,
    input  logic    rst_n,
    aqac_cfg_if     cfg,
    aqac_meas_if    meas,
    aqac_result_if  res,
    output int      fail_count,
    output int      pending
);

    localparam int PROD_BITS = aqac_pkg::DUST_RAW_W + aqac_pkg::GAIN_W;

    // Mirror of the threshold registers
    logic [aqac_pkg::GAS_W-1:0]   gas_warn;
    logic [aqac_pkg::GAS_W-1:0]   gas_haz;
    logic [aqac_pkg::DUST_W-1:0]  dust_warn;
    logic [aqac_pkg::DUST_W-1:0]  dust_haz;
    logic [aqac_pkg::INDEX_W-1:0] index_haz;
    logic [aqac_pkg::GAIN_W-1:0]  gain;

    // Mirror of the alarm state
    aqac_pkg::status_t last_status;
    logic              armed;
    logic              fan_on;
    logic              led_on;

    aqac_pkg::result_t verdict_q[$];
    aqac_pkg::result_t want;
    int                mismatches;
    int                results_seen;

    function automatic aqac_pkg::result_t classify_reading(
        input logic [aqac_pkg::GAS_W-1:0] gas,
        input logic [aqac_pkg::DUST_RAW_W-1:0] raw);
        logic [PROD_BITS-1:0] product;
        int unsigned          scaled;
        int unsigned          seen_dust;
        int unsigned          sum;
        int unsigned          drop;
        aqac_pkg::status_t    st;
        logic                 fan_next;
        aqac_pkg::result_t    r;
        r = '0;
        product = PROD_BITS'(raw) * PROD_BITS'(gain);
        scaled = 32'(product >> aqac_pkg::GAIN_FRAC);
        if (scaled > 65535)
            scaled = 65535;
        // only the index sees the clamped readings
        seen_dust = (scaled > aqac_pkg::ADC_FULL_SCALE) ? aqac_pkg::ADC_FULL_SCALE : scaled;
        sum = 32'(gas) + seen_dust;
        drop = (aqac_pkg::INDEX_MAX * sum + aqac_pkg::ADC_FULL_SCALE)
               / (2 * aqac_pkg::ADC_FULL_SCALE);
        if (drop > aqac_pkg::INDEX_MAX)
            drop = aqac_pkg::INDEX_MAX;

        if (gas > gas_haz || scaled > 32'(dust_haz)
            || (aqac_pkg::INDEX_MAX - drop) < 32'(index_haz))
            st = aqac_pkg::ST_HAZ;
        else if (gas > gas_warn || scaled > 32'(dust_warn))
            st = aqac_pkg::ST_WARN;
        else
            st = aqac_pkg::ST_SAFE;

        r.buzzer_pulse = aqac_pkg::BUZZ_NONE;
        if (st == aqac_pkg::ST_SAFE)
        begin
            fan_next = 1'b0;
            led_on = 1'b0;
            armed = 1'b1;
        end
        else
        begin
            fan_next = 1'b1;
            led_on = 1'b1;
            if (armed)
            begin
                if (st == aqac_pkg::ST_HAZ)
                    r.buzzer_pulse = aqac_pkg::BUZZ_LONG;
                else
                    r.buzzer_pulse = aqac_pkg::BUZZ_SHORT;
                armed = 1'b0;
            end
        end

        r.status_event = aqac_pkg::SEV_NONE;
        if (st != last_status)
        begin
            if (st == aqac_pkg::ST_HAZ)
                r.status_event = aqac_pkg::SEV_HAZARD;
            else
                r.status_event = aqac_pkg::SEV_CHANGE;
            last_status = st;
        end

        r.fan_event = aqac_pkg::FEV_NONE;
        if (fan_next && !fan_on)
            r.fan_event = aqac_pkg::FEV_ON;
        else if (!fan_next && fan_on)
            r.fan_event = aqac_pkg::FEV_OFF;
        fan_on = fan_next;

        r.air_status = st;
        r.clean_index = aqac_pkg::INDEX_W'(aqac_pkg::INDEX_MAX - drop);
        r.dust_scaled = scaled[aqac_pkg::DUST_W-1:0];
        r.fan_drive = fan_on;
        r.led_drive = led_on;
        return r;
    endfunction

    task automatic compare_field(input string field, input int unsigned want_v,
                                 input int unsigned got_v);
        if (want_v != got_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] result %0d: %s expected %0d, got %0d",
                         $realtime, results_seen, field, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gas_warn = aqac_pkg::GAS_W'(aqac_pkg::GAS_WARN_RST);
            gas_haz = aqac_pkg::GAS_W'(aqac_pkg::GAS_HAZ_RST);
            dust_warn = aqac_pkg::DUST_W'(aqac_pkg::DUST_WARN_RST);
            dust_haz = aqac_pkg::DUST_W'(aqac_pkg::DUST_HAZ_RST);
            index_haz = aqac_pkg::INDEX_W'(aqac_pkg::INDEX_HAZ_RST);
            gain = aqac_pkg::GAIN_W'(aqac_pkg::DUST_GAIN_RST);
            last_status = aqac_pkg::ST_SAFE;
            armed = 1'b1;
            fan_on = 1'b0;
            led_on = 1'b0;
            verdict_q.delete();
            mismatches = 0;
            results_seen = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    aqac_pkg::CFG_GAS_WARN:  gas_warn = cfg.data[aqac_pkg::GAS_W-1:0];
                    aqac_pkg::CFG_GAS_HAZ:   gas_haz = cfg.data[aqac_pkg::GAS_W-1:0];
                    aqac_pkg::CFG_DUST_WARN: dust_warn = cfg.data[aqac_pkg::DUST_W-1:0];
                    aqac_pkg::CFG_DUST_HAZ:  dust_haz = cfg.data[aqac_pkg::DUST_W-1:0];
                    aqac_pkg::CFG_INDEX_HAZ: index_haz = cfg.data[aqac_pkg::INDEX_W-1:0];
                    aqac_pkg::CFG_DUST_GAIN: gain = cfg.data[aqac_pkg::GAIN_W-1:0];
                    default:                 ;
                endcase
            end

            if (meas.valid && meas.ready)
                verdict_q.push_back(classify_reading(meas.gas_level, meas.dust_sample));

            if (res.valid && res.ready)
            begin
                results_seen++;
                if (verdict_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result %0d arrived with no measurement outstanding",
                                 $realtime, results_seen);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    compare_field("air_status", 32'(want.air_status), 32'(res.air_status));
                    compare_field("clean_index", 32'(want.clean_index), 32'(res.clean_index));
                    compare_field("dust_scaled", 32'(want.dust_scaled), 32'(res.dust_scaled));
                    compare_field("fan_drive", 32'(want.fan_drive), 32'(res.fan_drive));
                    compare_field("led_drive", 32'(want.led_drive), 32'(res.led_drive));
                    compare_field("buzzer_pulse", 32'(want.buzzer_pulse),
                                  32'(res.buzzer_pulse));
                    compare_field("status_event", 32'(want.status_event),
                                  32'(res.status_event));
                    compare_field("fan_event", 32'(want.fan_event), 32'(res.fan_event));
                end
            end

            fail_count <= mismatches;
            pending <= verdict_q.size();
        end
    end

endmodule

@@ dv/tb_air_quality_alarm_classifier.sv @@
// tb_air_quality_alarm_classifier: stimulus and verdict for the air quality alarm classifier.
// Depends on aqac_pkg, aqac_if.sv, the block itself and dv/aqac_verdict_checker.sv.
`timescale 1ns / 1ps

module tb_air_quality_alarm_classifier;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 6;
    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 103;
    localparam int CHOKE_ITEMS     = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    // no acceptance on any channel for this long means the block is wedged;
    // the longest legal quiet stretch is the receiver hold-off
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_PAUSE     = 8;

    // Register indexes the block does not decode; writes to them must be dropped
    localparam logic [aqac_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [aqac_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 3'd7;

    // Receiver stall patterns
    localparam int SINK_OPEN     = 0;
    localparam int SINK_COIN     = 1;
    localparam int SINK_PERIODIC = 2;
    localparam int SINK_CHOKED   = 3;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   hold_req = 0;

    // last value written to each register, used to aim readings at the thresholds
    int unsigned shadow [6] = '{aqac_pkg::GAS_WARN_RST, aqac_pkg::GAS_HAZ_RST,
                                aqac_pkg::DUST_WARN_RST, aqac_pkg::DUST_HAZ_RST,
                                aqac_pkg::INDEX_HAZ_RST, aqac_pkg::DUST_GAIN_RST};

    aqac_cfg_if    cfg_ch();
    aqac_meas_if   meas_ch();
    aqac_result_if res_ch();

    air_quality_alarm_classifier dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .meas  (meas_ch),
        .res   (res_ch)
    );

    aqac_verdict_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_ch),
        .meas       (meas_ch),
        .res        (res_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Reading generators
    // ------------------------------------------------------------------

    // Land within a few counts of a threshold, clipped to the field range.
    function automatic int unsigned near_level(input int unsigned center,
                                               input int unsigned ceiling);
        int unsigned v;
        v = center + $urandom_range(0, 6);
        v = (v < 3) ? 0 : v - 3;
        return (v > ceiling) ? ceiling : v;
    endfunction

    function automatic int unsigned pick_gas();
        int unsigned warn;
        int unsigned haz;
        warn = shadow[aqac_pkg::CFG_GAS_WARN] & 'hFFF;
        haz = shadow[aqac_pkg::CFG_GAS_HAZ] & 'hFFF;
        case ($urandom_range(0, 9))
            0, 1, 2: return near_level(warn, 4095);
            3, 4:    return near_level(haz, 4095);
            5, 6:    return $urandom_range(0, warn);
            7:       return $urandom_range(0, 1) ? 4095 : 0;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    // Dust thresholds apply after the gain, so back the target out through it.
    function automatic int unsigned pick_dust();
        int unsigned gn;
        int unsigned warn_raw;
        int unsigned haz_raw;
        gn = shadow[aqac_pkg::CFG_DUST_GAIN] & 'hFFFF;
        if (gn == 0)
            return $urandom_range(0, 4095);
        warn_raw = ((shadow[aqac_pkg::CFG_DUST_WARN] & 'hFFFF) * 256) / gn;
        haz_raw = ((shadow[aqac_pkg::CFG_DUST_HAZ] & 'hFFFF) * 256) / gn;
        if (warn_raw > 4095)
            warn_raw = 4095;
        case ($urandom_range(0, 9))
            0, 1, 2: return near_level(warn_raw, 4095);
            3, 4:    return near_level(haz_raw, 4095);
            5, 6:    return $urandom_range(0, warn_raw);
            7:       return $urandom_range(0, 1) ? 4095 : 0;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Offer one measurement request and hold it until the block takes it.
    // Valid is left high so a following request goes out back to back.
    task automatic send_meas(input int unsigned gas, input int unsigned dust);
        meas_ch.valid <= 1'b1;
        meas_ch.gas_level <= gas[aqac_pkg::GAS_W-1:0];
        meas_ch.dust_sample <= dust[aqac_pkg::DUST_RAW_W-1:0];
        do @(posedge clk); while (!meas_ch.ready);
    endtask

    task automatic write_reg(input logic [aqac_pkg::CFG_INDEX_W-1:0] idx,
                             input int unsigned data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data[aqac_pkg::CFG_DATA_W-1:0];
        if (idx <= aqac_pkg::CFG_DUST_GAIN)
            shadow[idx] = data;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // Write all six registers plus one undecoded index, then drop valid.
    task automatic configure(input int unsigned gw, input int unsigned gh,
                             input int unsigned dw, input int unsigned dh,
                             input int unsigned ih, input int unsigned gn);
        write_reg(aqac_pkg::CFG_GAS_WARN, gw);
        write_reg(aqac_pkg::CFG_GAS_HAZ, gh);
        write_reg(aqac_pkg::CFG_DUST_WARN, dw);
        write_reg(aqac_pkg::CFG_DUST_HAZ, dh);
        write_reg(aqac_pkg::CFG_INDEX_HAZ, ih);
        write_reg(aqac_pkg::CFG_DUST_GAIN, gn);
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stop offering and wait for every outstanding result. The first edge lets
    // the checker's count catch up with a request taken at this very edge.
    task automatic settle();
        meas_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Random measurements in bursts with random gaps. With choke set, first
    // ask the receiver for a long hold-off and keep offering with no gaps so
    // the pipeline fills and backs up into the input.
    task automatic run_phase(input int count, input bit choke);
        int sent;
        int burst;
        int gap;
        sent = 0;
        if (choke)
        begin
            hold_req <= hold_req + 1;
            for (int k = 0; k < CHOKE_ITEMS; k++)
                send_meas(pick_gas(), pick_dust());
            sent = CHOKE_ITEMS;
        end
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < count; k++)
            begin
                send_meas(pick_gas(), pick_dust());
                sent++;
            end
            // a zero gap keeps valid high straight into the next burst
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                meas_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result receiver: switch stall pattern at random intervals, and
    // serve a long hold-off whenever the stimulus asks for one.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int hold_done;
        int mode;
        int left;
        hold_done = 0;
        mode = SINK_OPEN;
        left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_done)
            begin
                hold_done = hold_req;
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(SINK_OPEN, SINK_CHOKED);
                    left = $urandom_range(8, 80);
                end
                left--;
                case (mode)
                    SINK_OPEN:     res_ch.ready <= 1'b1;
                    SINK_COIN:     res_ch.ready <= 1'($urandom_range(0, 1));
                    SINK_PERIODIC: res_ch.ready <= (left % 4 == 0);
                    default:       res_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no channel moves a request for too long.
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((meas_ch.valid && meas_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("air_quality_alarm_classifier verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned gw;
        int unsigned gh;
        int unsigned dw;
        int unsigned dh;
        int unsigned ih;
        int unsigned gn;

        // drive every input to a known value before the first edge
        rst_n <= 1'b0;
        meas_ch.valid <= 1'b0;
        meas_ch.gas_level <= '0;
        meas_ch.dust_sample <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data <= '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset thresholds: extremes, both edges of the gas and dust thresholds,
        // and the alarm latch walking through an excursion and back.
        send_meas(0, 0);          // cleanest air, index at the top
        send_meas(4095, 4095);    // hazardous, index at zero, long buzz
        send_meas(4095, 4095);    // still hazardous, latch already spent
        send_meas(0, 0);          // back to safe: fan off, latch re-armed
        send_meas(1500, 0);       // gas on the warning level, still safe
        send_meas(1501, 0);       // warning, short buzz
        send_meas(2500, 0);       // warning held, no second buzz
        send_meas(2501, 0);       // escalate to hazardous without a buzz
        send_meas(0, 1500);       // dust on the warning level, safe
        send_meas(0, 1501);       // dust warning
        send_meas(0, 2500);
        send_meas(0, 2501);       // dust hazardous
        send_meas(0, 0);
        send_meas(2500, 2500);    // hazardous from the index alone
        send_meas(1200, 1200);    // safe again

        // Dust thresholds above full scale: comparisons use the unclamped
        // scaled reading while the index uses the clamped one.
        settle();
        configure(aqac_pkg::GAS_WARN_RST, aqac_pkg::GAS_HAZ_RST, 4500, 60000, 0, 4096);
        send_meas(0, 281);
        send_meas(0, 282);
        send_meas(0, 3750);
        send_meas(0, 3751);

        // Largest gain saturates the product; nothing can trip.
        settle();
        configure(4095, 4095, 65535, 65535, 0, 65535);
        send_meas(0, 4095);
        send_meas(4095, 0);

        // Index threshold past the top of the index: every reading hazardous.
        settle();
        configure(0, 0, 0, 0, 1023, 0);
        send_meas(0, 0);
        send_meas(0, 4095);

        // Random phases, each with its own register setting. The pause before
        // each configure also covers the sender waiting out every result.
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0:
                begin
                    gw = aqac_pkg::GAS_WARN_RST;   gh = aqac_pkg::GAS_HAZ_RST;
                    dw = aqac_pkg::DUST_WARN_RST;  dh = aqac_pkg::DUST_HAZ_RST;
                    ih = aqac_pkg::INDEX_HAZ_RST;  gn = aqac_pkg::DUST_GAIN_RST;
                end
                1:
                begin
                    // all ones but the index threshold; narrow registers keep their low bits
                    gw = 'hFFFF;  gh = 'hFFFF;  dw = 'hFFFF;
                    dh = 'hFFFF;  ih = 'hFC00;  gn = 'hFFFF;
                end
                2:
                begin
                    gw = 0;  gh = 0;  dw = 0;  dh = 0;  ih = 0;  gn = 1;
                end
                3:
                begin
                    gw = 3000;  gh = 3500;  dw = 3000;  dh = 3500;  ih = 1023;  gn = 128;
                end
                default:
                begin
                    gw = $urandom_range(200, 3500);
                    // occasionally put the hazard level at or under the warning level
                    gh = ($urandom_range(0, 4) == 0) ? $urandom_range(0, gw)
                                                     : gw + $urandom_range(0, 595);
                    dw = $urandom_range(200, 6000);
                    dh = ($urandom_range(0, 4) == 0) ? $urandom_range(0, dw)
                                                     : dw + $urandom_range(0, 2000);
                    ih = $urandom_range(0, 700);
                    case ($urandom_range(0, 2))
                        0:       gn = 256;
                        1:       gn = $urandom_range(16, 2048);
                        default: gn = $urandom_range(0, 65535);
                    endcase
                end
            endcase
            configure(gw, gh, dw, dh, ih, gn);
            run_phase(PHASE_ITEMS, p == 4);
        end

        // Let every result come back, then allow the pipeline to go quiet.
        settle();
        repeat (DRAIN_PAUSE) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("air_quality_alarm_classifier verification clean");
        else
            $display("air_quality_alarm_classifier verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/aqac_pkg.sv
sv/aqac_if.sv
sv/air_quality_alarm_classifier.sv
dv/aqac_verdict_checker.sv
dv/tb_air_quality_alarm_classifier.sv
